// ===== rtl/resub_relation_builder_defines.svh =====
// assertion macros shared by the relation builder modules
`ifndef RESUB_RELATION_BUILDER_DEFINES_SVH
`define RESUB_RELATION_BUILDER_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define RRB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never hold outside reset
`define RRB_ASSERT_NEVER(lbl, cond, msg) \
  `RRB_ASSERT(lbl, !(cond), msg)

`endif

// ===== rtl/rrb_pkg.sv =====
`default_nettype none

package rrb_pkg;

  // table geometry
  localparam int MaxSelected = 6;
  localparam int NumDivisors = 64;
  localparam int IdxW        = MaxSelected;
  localparam int TableDepth  = 1 << MaxSelected;

  // field widths
  localparam int CountW   = 3;
  localparam int SelW     = 6;
  localparam int DivBitsW = 64;
  localparam int OpW      = 2;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 6;
  localparam int InDataW  = 72;
  localparam int OutDataW = 8;

  // entry permission bits
  localparam logic [1:0] AllowZero  = 2'b01;
  localparam logic [1:0] AllowOne   = 2'b10;
  localparam logic [1:0] AllAllowed = 2'b11;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegSelectedCount = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSelect0       = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSelect5       = 3'd6;

  typedef enum logic [OpW-1:0] {
    OP_START   = 2'd0,
    OP_MINTERM = 2'd1,
    OP_READOUT = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MT_WRITE,
    ST_RO_LOAD
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic clear;     // start item: every entry back to all allowed
    logic mt_read;   // minterm accepted: latch index, read entry
    logic mt_write;  // write back the narrowed entry
    logic ro_first;  // readout accepted: read entry 0
    logic ro_load;   // move current entry into the output register
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic slot_free;  // output register empty or being taken
    logic at_last;    // current readout entry is the final one
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/rrb_ctrl.sv =====
`default_nettype none

`include "resub_relation_builder_defines.svh"

module rrb_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  input  wire logic [rrb_pkg::OpW-1:0] opcode_i,
  output logic                        in_ready_o,
  input  wire rrb_pkg::status_t        status_i,
  output rrb_pkg::cmd_t               cmd_o
);

  rrb_pkg::state_e state_q, state_d;
  logic            accept;

  // item taken only while idle
  assign accept = in_valid_i && (state_q == rrb_pkg::ST_IDLE);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rrb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rrb_pkg::ST_IDLE: begin
        if (accept) begin
          if (opcode_i == rrb_pkg::OP_MINTERM) begin
            state_d = rrb_pkg::ST_MT_WRITE;
          end else if (opcode_i == rrb_pkg::OP_READOUT) begin
            state_d = rrb_pkg::ST_RO_LOAD;
          end
        end
      end
      rrb_pkg::ST_MT_WRITE: begin
        state_d = rrb_pkg::ST_IDLE;
      end
      rrb_pkg::ST_RO_LOAD: begin
        if (status_i.slot_free && status_i.at_last) begin
          state_d = rrb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rrb_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      rrb_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          unique case (rrb_pkg::opcode_e'(opcode_i))
            rrb_pkg::OP_START:   cmd_o.clear    = 1'b1;
            rrb_pkg::OP_MINTERM: cmd_o.mt_read  = 1'b1;
            rrb_pkg::OP_READOUT: cmd_o.ro_first = 1'b1;
            default: ;
          endcase
        end
      end
      rrb_pkg::ST_MT_WRITE: begin
        cmd_o.mt_write = 1'b1;
      end
      rrb_pkg::ST_RO_LOAD: begin
        cmd_o.ro_load = status_i.slot_free;
      end
      default: ;
    endcase
  end

  // checks
  `RRB_ASSERT(a_write_after_minterm,
              cmd_o.mt_write |-> $past(accept && opcode_i == rrb_pkg::OP_MINTERM),
              "table write without a minterm item")
  `RRB_ASSERT(a_last_returns_idle, (cmd_o.ro_load && status_i.at_last) |=> in_ready_o,
              "controller not idle after final readout entry")
  `RRB_ASSERT_NEVER(a_load_blocked, cmd_o.ro_load && !status_i.slot_free,
                    "output register overwritten while occupied")

endmodule

`default_nettype wire

// ===== rtl/rrb_datapath.sv =====
`default_nettype none

`include "resub_relation_builder_defines.svh"

module rrb_datapath (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration writes
  input  wire logic                         cfg_we_i,
  input  wire logic [rrb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [rrb_pkg::CfgDataW-1:0] cfg_data_i,
  // input item payload
  input  wire logic                         target_bit_i,
  input  wire logic [rrb_pkg::DivBitsW-1:0] divisor_bits_i,
  // control
  input  wire rrb_pkg::cmd_t                cmd_i,
  output rrb_pkg::status_t                  status_o,
  // result register
  input  wire logic                         out_ready_i,
  output logic                              out_valid_o,
  output logic [rrb_pkg::IdxW-1:0]          entry_index_o,
  output logic                              may_be_zero_o,
  output logic                              may_be_one_o,
  output logic                              last_o
);

  logic [rrb_pkg::CountW-1:0] count_q;
  logic [rrb_pkg::SelW-1:0]   sel_q [rrb_pkg::MaxSelected];
  logic [rrb_pkg::CountW-1:0] k_eff;
  logic [rrb_pkg::CfgIdxW-1:0] sel_slot;

  logic [rrb_pkg::IdxW-1:0]   idx;
  logic [rrb_pkg::IdxW:0]     span;
  logic [rrb_pkg::IdxW-1:0]   addr_q, addr_next, rd_addr;
  logic [rrb_pkg::IdxW-1:0]   last_idx_q;
  logic                       target_q;
  logic                       rd_en;

  logic [1:0]                 table_mem [rrb_pkg::TableDepth];
  logic [rrb_pkg::TableDepth-1:0] valid_q;
  logic [1:0]                 rdata_q;
  logic                       rvalid_q;
  logic [1:0]                 entry, entry_new;

  logic                       out_valid_q, out_valid_d;
  logic [rrb_pkg::IdxW-1:0]   out_idx_q;
  logic [1:0]                 out_entry_q;
  logic                       out_last_q;

  // configuration registers
  assign sel_slot = cfg_index_i - rrb_pkg::RegSelect0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int i = 0; i < rrb_pkg::MaxSelected; i++) begin
        sel_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_index_i == rrb_pkg::RegSelectedCount) begin
        count_q <= cfg_data_i[rrb_pkg::CountW-1:0];
      end else if (cfg_index_i >= rrb_pkg::RegSelect0 && cfg_index_i <= rrb_pkg::RegSelect5) begin
        sel_q[sel_slot] <= cfg_data_i[rrb_pkg::SelW-1:0];
      end
    end
  end

  // active selection count, capped at MaxSelected
  assign k_eff = (count_q > rrb_pkg::CountW'(rrb_pkg::MaxSelected))
               ? rrb_pkg::CountW'(rrb_pkg::MaxSelected) : count_q;

  // pattern index from the selected divisors
  always_comb begin
    for (int i = 0; i < rrb_pkg::IdxW; i++) begin
      idx[i] = (rrb_pkg::CountW'(i) < k_eff)
            && (int'(sel_q[i]) < rrb_pkg::NumDivisors)
            && divisor_bits_i[sel_q[i]];
    end
  end

  // highest index of a readout run
  assign span = ((rrb_pkg::IdxW+1)'(1) << k_eff) - (rrb_pkg::IdxW+1)'(1);

  // address and readout counter
  assign addr_next = addr_q + rrb_pkg::IdxW'(1);
  assign status_o.at_last = (addr_q == last_idx_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mt_read) begin
      addr_q   <= idx;
      target_q <= target_bit_i;
    end else if (cmd_i.ro_first) begin
      addr_q     <= '0;
      last_idx_q <= span[rrb_pkg::IdxW-1:0];
    end else if (cmd_i.ro_load && !status_o.at_last) begin
      addr_q <= addr_next;
    end
  end

  // table read port
  assign rd_en   = cmd_i.mt_read || cmd_i.ro_first || (cmd_i.ro_load && !status_o.at_last);
  assign rd_addr = cmd_i.mt_read ? idx : (cmd_i.ro_first ? '0 : addr_next);

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q  <= table_mem[rd_addr];
      rvalid_q <= valid_q[rd_addr];
    end
  end

  // an entry not written since start reads as all allowed
  assign entry     = rvalid_q ? rdata_q : rrb_pkg::AllAllowed;
  assign entry_new = entry & (target_q ? ~rrb_pkg::AllowZero : ~rrb_pkg::AllowOne);

  // table write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.mt_write) begin
      table_mem[addr_q] <= entry_new;
    end
  end

  // entry valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.clear) begin
      valid_q <= '0;
    end else if (cmd_i.mt_write) begin
      valid_q[addr_q] <= 1'b1;
    end
  end

  // output register
  assign status_o.slot_free = !out_valid_q || out_ready_i;
  assign out_valid_d        = cmd_i.ro_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ro_load) begin
      out_idx_q   <= addr_q;
      out_entry_q <= entry;
      out_last_q  <= status_o.at_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign entry_index_o = out_idx_q;
  assign may_be_zero_o = out_entry_q[0];
  assign may_be_one_o  = out_entry_q[1];
  assign last_o        = out_last_q;

  // checks
  `RRB_ASSERT(a_write_sets_valid, cmd_i.mt_write |=> valid_q[$past(addr_q)],
              "written entry not marked valid")
  `RRB_ASSERT(a_start_clears, cmd_i.clear |=> (valid_q == '0),
              "start item left entries valid")
  `RRB_ASSERT(a_load_fills_slot, cmd_i.ro_load |=> out_valid_q,
              "loaded entry not presented")

endmodule

`default_nettype wire

// ===== rtl/resub_relation_builder.sv =====
// start item clears the entry valid bits; minterm item reads its table entry, then writes it back narrowed
// readout: 2^k entries, each through the table read register and then the output register
// one entry per cycle unless the output stalls; items are taken one at a time, only while idle
// the final readout entry may still wait in the output register while the next item enters
// reset: asynchronous, active low; control and configuration registers zero, entry valid bits
// cleared at once, so the whole table reads as all allowed with no clearing pass
`default_nettype none

module resub_relation_builder (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write channel
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [rrb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [rrb_pkg::CfgDataW-1:0]  cfg_data_i,
  // input items
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: target_bit [0], divisor_bits [64:1], zero [71:65]
  input  wire logic [rrb_pkg::InDataW-1:0]   s_axis_tdata,
  // tuser: opcode [1:0]
  input  wire logic [rrb_pkg::OpW-1:0]       s_axis_tuser,
  // result items
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // tdata: entry_index [5:0], may_be_zero [6], may_be_one [7]
  output logic [rrb_pkg::OutDataW-1:0]       m_axis_tdata,
  output logic                               m_axis_tlast
);

  rrb_pkg::cmd_t              cmd;
  rrb_pkg::status_t           status;
  logic [rrb_pkg::IdxW-1:0]   entry_index;
  logic                       may_be_zero;
  logic                       may_be_one;

  assign cfg_ready_o = 1'b1;

  // sequencing
  rrb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .opcode_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // table, configuration and result register
  rrb_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .target_bit_i   (s_axis_tdata[0]),
    .divisor_bits_i (s_axis_tdata[rrb_pkg::DivBitsW:1]),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .entry_index_o  (entry_index),
    .may_be_zero_o  (may_be_zero),
    .may_be_one_o   (may_be_one),
    .last_o         (m_axis_tlast)
  );

  assign m_axis_tdata = {may_be_one, may_be_zero, entry_index};

endmodule

`default_nettype wire
